// ----- design/cheb_pkg.sv -----
package cheb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_ORDER = 63;

    localparam int DEG_W   = 6;
    localparam int VAL_W   = 18;
    localparam int U_W     = 24;
    localparam int SLOPE_W = 29;
    localparam int PROD_W  = 2 * U_W;
    localparam int DIFF_W  = PROD_W + 1;

    localparam logic [DEG_W-1:0]          ORDER_RESET = DEG_W'(16);
    localparam logic [DEG_W-1:0]          ORDER_MAX   = DEG_W'(MAX_ORDER);
    localparam logic signed [VAL_W-1:0]   ONE_FX      = VAL_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [U_W-1:0]     U_ONE       = U_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [U_W-1:0]     U_LIM       =
        U_W'(64'(MAX_ORDER) * (64'sd1 <<< FRAC_BITS));
    localparam logic signed [SLOPE_W-1:0] SLOPE_ONE   = SLOPE_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [SLOPE_W-1:0] S_LIM       =
        SLOPE_W'(64'(MAX_ORDER) * 64'(MAX_ORDER) * (64'sd1 <<< FRAC_BITS));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_U,
        ST_MUL_S,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_T,
        OP_U,
        OP_S
    } mul_op_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [DIFF_W-1:0] x);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(ONE_FX);
        lo = -hi;
        if (x > hi)
            return ONE_FX;
        else if (x < lo)
            return -ONE_FX;
        else
            return VAL_W'(x);
    endfunction

    function automatic logic signed [U_W-1:0] sat_u(input logic signed [DIFF_W-1:0] x);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(U_LIM);
        lo = -hi;
        if (x > hi)
            return U_LIM;
        else if (x < lo)
            return -U_LIM;
        else
            return U_W'(x);
    endfunction

    function automatic logic signed [SLOPE_W-1:0] sat_slope(
        input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(S_LIM);
        lo = -hi;
        if (x > hi)
            return S_LIM;
        else if (x < lo)
            return -S_LIM;
        else
            return SLOPE_W'(x);
    endfunction

endpackage

// ----- design/chebyshev_basis_with_derivative_core.sv -----
// Chebyshev first-kind basis T_i(t) and derivative i*U_{i-1}(t), degrees 0..order per node.
// Each node starts at degree 0 in ST_EMIT. Degrees 0 and 1 are loaded by ST_EMIT alone,
// every higher degree takes 3 passes through the shared multiplier (ST_MUL_T, ST_MUL_U,
// ST_MUL_S) plus the output load in ST_EMIT, which waits while a result is stalled.
// node_stall is high from node acceptance until the last result is loaded.
// Reset (async, rst_n low): sequencer idle, output invalid, order = 16.
module chebyshev_basis_with_derivative_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   order_we,
    input  logic        [cheb_pkg::DEG_W-1:0]      order_wdata,
    input  logic                                   node_valid,
    output logic                                   node_stall,
    input  logic signed [cheb_pkg::VAL_W-1:0]      node,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output logic        [cheb_pkg::DEG_W-1:0]      degree,
    output logic signed [cheb_pkg::VAL_W-1:0]      value,
    output logic signed [cheb_pkg::SLOPE_W-1:0]    slope,
    output logic                                   last
);
    import cheb_pkg::*;

    state_t                     state_reg, state_next;
    logic [DEG_W-1:0]           order_reg;
    logic [DEG_W-1:0]           deg_reg, deg_next;
    logic [DEG_W-1:0]           n_reg, n_next;
    logic                       res_valid_reg, res_valid_next;

    logic signed [VAL_W-1:0]    t_reg, t_next;
    logic signed [VAL_W-1:0]    tp0_reg, tp0_next;
    logic signed [VAL_W-1:0]    tp1_reg, tp1_next;
    logic signed [U_W-1:0]      up0_reg, up0_next;
    logic signed [U_W-1:0]      up1_reg, up1_next;
    logic signed [VAL_W-1:0]    val_reg, val_next;
    logic signed [U_W-1:0]      u_reg, u_next;

    logic [DEG_W-1:0]           degree_reg, degree_next;
    logic signed [VAL_W-1:0]    value_reg, value_next;
    logic signed [SLOPE_W-1:0]  slope_reg, slope_next;
    logic                       last_reg, last_next;

    mul_op_t                    mul_op;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [VAL_W-1:0]    node_sat;
    logic                       node_acc;
    logic                       out_free;

    cheb_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .t    (t_reg),
        .tp0  (tp0_reg),
        .up0  (up0_reg),
        .deg  (deg_reg),
        .prod (prod)
    );

    assign node_stall = (state_reg != ST_IDLE);
    assign node_acc   = node_valid && !node_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign prod_sh    = prod >>> (FRAC_BITS - 1);

    always_comb
    begin
        if (node > ONE_FX)
            node_sat = ONE_FX;
        else if (node < -ONE_FX)
            node_sat = -ONE_FX;
        else
            node_sat = node;
    end

    always_comb
    begin
        state_next     = state_reg;
        deg_next       = deg_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        tp0_next       = tp0_reg;
        tp1_next       = tp1_reg;
        up0_next       = up0_reg;
        up1_next       = up1_reg;
        val_next       = val_reg;
        u_next         = u_reg;
        degree_next    = degree_reg;
        value_next     = value_reg;
        slope_next     = slope_reg;
        last_next      = last_reg;
        mul_op         = OP_NONE;
        res_valid_next = res_stall ? res_valid_reg : 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (node_acc)
                begin
                    t_next     = node_sat;
                    deg_next   = '0;
                    n_next     = (order_reg > ORDER_MAX) ? ORDER_MAX : order_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_MUL_T:
            begin
                mul_op     = OP_T;
                state_next = ST_MUL_U;
            end
            ST_MUL_U:
            begin
                mul_op     = OP_U;
                val_next   = sat_val(DIFF_W'(prod_sh) - DIFF_W'(tp1_reg));
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                mul_op     = OP_S;
                u_next     = sat_u(DIFF_W'(prod_sh) - DIFF_W'(up1_reg));
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    degree_next    = deg_reg;
                    last_next      = (deg_reg == n_reg);
                    if (deg_reg == '0)
                    begin
                        value_next = ONE_FX;
                        slope_next = '0;
                        tp0_next   = ONE_FX;
                        tp1_next   = '0;
                        up0_next   = U_ONE;
                        up1_next   = '0;
                    end
                    else if (deg_reg == DEG_W'(1))
                    begin
                        value_next = t_reg;
                        slope_next = SLOPE_ONE;
                        tp0_next   = t_reg;
                        tp1_next   = tp0_reg;
                        up0_next   = sat_u(DIFF_W'(t_reg) <<< 1);
                        up1_next   = up0_reg;
                    end
                    else
                    begin
                        value_next = val_reg;
                        slope_next = sat_slope(prod);
                        tp0_next   = val_reg;
                        tp1_next   = tp0_reg;
                        up0_next   = u_reg;
                        up1_next   = up0_reg;
                    end
                    if (deg_reg == n_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        deg_next   = deg_reg + DEG_W'(1);
                        state_next = (deg_reg == '0) ? ST_EMIT : ST_MUL_T;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= ORDER_RESET;
            deg_reg       <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deg_reg       <= deg_next;
            n_reg         <= n_next;
            res_valid_reg <= res_valid_next;
            if (order_we)
                order_reg <= order_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        tp0_reg    <= tp0_next;
        tp1_reg    <= tp1_next;
        up0_reg    <= up0_next;
        up1_reg    <= up1_next;
        val_reg    <= val_next;
        u_reg      <= u_next;
        degree_reg <= degree_next;
        value_reg  <= value_next;
        slope_reg  <= slope_next;
        last_reg   <= last_next;
    end

    assign res_valid = res_valid_reg;
    assign degree    = degree_reg;
    assign value     = value_reg;
    assign slope     = slope_reg;
    assign last      = last_reg;

    a_acc_starts_deg0: assert property (@(posedge clk) disable iff (!rst_n)
        node_acc |=> (state_reg == ST_EMIT) && (deg_reg == '0))
        else $error("node transaction did not start at degree 0");

    a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (deg_reg <= n_reg) && (n_reg <= ORDER_MAX))
        else $error("degree counter past order");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (value_reg <= ONE_FX) && (value_reg >= -ONE_FX))
        else $error("value out of range");

    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_T) |-> (up0_reg <= U_LIM) && (up0_reg >= -U_LIM))
        else $error("second-kind term out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && out_free && (deg_reg == n_reg) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return idle after last result");

endmodule

// ----- design/cheb_mul.sv -----
module cheb_mul (
    input  logic                                   clk,
    input  cheb_pkg::mul_op_t                      op,
    input  logic signed [cheb_pkg::VAL_W-1:0]      t,
    input  logic signed [cheb_pkg::VAL_W-1:0]      tp0,
    input  logic signed [cheb_pkg::U_W-1:0]        up0,
    input  logic        [cheb_pkg::DEG_W-1:0]      deg,
    output logic signed [cheb_pkg::PROD_W-1:0]     prod
);
    import cheb_pkg::*;

    logic signed [U_W-1:0]    op_a;
    logic signed [U_W-1:0]    op_b;
    logic signed [PROD_W-1:0] prod_reg;

    always_comb
    begin
        case (op)
            OP_T:
            begin
                op_a = U_W'(t);
                op_b = U_W'(tp0);
            end
            OP_U:
            begin
                op_a = U_W'(t);
                op_b = up0;
            end
            OP_S:
            begin
                op_a = signed'({{(U_W-DEG_W){1'b0}}, deg});
                op_b = up0;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op != OP_NONE)
            prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- tb/tb_chebyshev_basis_with_derivative_core.sv -----
`timescale 1ns / 1ps

module tb_chebyshev_basis_with_derivative_core;
    import cheb_pkg::*;

    localparam int     QUIET_LIMIT = 5000;
    localparam longint UNIT        = longint'(1) <<< FRAC_BITS;
    localparam longint U_CAP       = longint'(MAX_ORDER) * UNIT;
    localparam longint S_CAP       = longint'(MAX_ORDER) * longint'(MAX_ORDER) * UNIT;

    typedef struct packed {
        logic        [DEG_W-1:0]   deg;
        logic signed [VAL_W-1:0]   val;
        logic signed [SLOPE_W-1:0] slp;
        logic                      lst;
    } basis_res_t;

    logic                        clk;
    logic                        rst_n;
    logic                        order_we;
    logic        [DEG_W-1:0]     order_wdata;
    logic                        node_valid;
    logic                        node_stall;
    logic signed [VAL_W-1:0]     node;
    logic                        res_valid;
    logic                        res_stall;
    logic        [DEG_W-1:0]     degree;
    logic signed [VAL_W-1:0]     value;
    logic signed [SLOPE_W-1:0]   slope;
    logic                        last;

    basis_res_t basis_q[$];
    int         fail_count;
    int         quiet_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    // predictor state
    logic [DEG_W-1:0] order_cfg;
    longint           held_t;
    longint           t_hist[2];
    longint           u_hist[2];
    int               deg_count;

    chebyshev_basis_with_derivative_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .order_we    (order_we),
        .order_wdata (order_wdata),
        .node_valid  (node_valid),
        .node_stall  (node_stall),
        .node        (node),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .degree      (degree),
        .value       (value),
        .slope       (slope),
        .last        (last)
    );

    always #1 clk = ~clk;

    function automatic longint clamp(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // floor(2*a*b / 2^FRAC_BITS)
    function automatic longint twice_prod(input longint a, input longint b);
        return (2 * a * b) >>> FRAC_BITS;
    endfunction

    function automatic void expand_node(input logic signed [VAL_W-1:0] raw);
        longint     t;
        longint     v;
        longint     s;
        longint     u;
        int         n;
        basis_res_t r;
        t = clamp(longint'(raw), UNIT);
        n = (order_cfg > MAX_ORDER) ? MAX_ORDER : int'(order_cfg);
        held_t = t;
        for (int i = 0; i <= n; i++) begin
            if (i == 0) begin
                v = UNIT;
                s = 0;
                t_hist[0] = v;
                t_hist[1] = 0;
                u_hist[0] = UNIT;
                u_hist[1] = 0;
            end else if (i == 1) begin
                v = t;
                s = UNIT;
                t_hist[1] = t_hist[0];
                t_hist[0] = v;
                u_hist[1] = u_hist[0];
                u_hist[0] = clamp(2 * t, U_CAP);
            end else begin
                v = clamp(twice_prod(t, t_hist[0]) - t_hist[1], UNIT);
                s = clamp(longint'(i) * u_hist[0], S_CAP);
                u = clamp(twice_prod(t, u_hist[0]) - u_hist[1], U_CAP);
                t_hist[1] = t_hist[0];
                t_hist[0] = v;
                u_hist[1] = u_hist[0];
                u_hist[0] = u;
            end
            deg_count = i;
            r.deg = DEG_W'(i);
            r.val = v[VAL_W-1:0];
            r.slp = s[SLOPE_W-1:0];
            r.lst = (i == n);
            basis_q.push_back(r);
        end
    endfunction

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin : res_check
        basis_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (basis_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transaction: degree %0d value %0d slope %0d",
                             degree, value, slope);
            end
            else
            begin
                want = basis_q.pop_front();
                if (want.deg !== degree || want.val !== value ||
                    want.slp !== slope || want.lst !== last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp deg %0d val %0d slope %0d last %0b, got deg %0d val %0d slope %0d last %0b",
                                 want.deg, want.val, want.slp, want.lst,
                                 degree, value, slope, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((node_valid && !node_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("** chebyshev_basis_with_derivative_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    task automatic send_node(input logic signed [VAL_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        node_valid = 1'b1;
        node       = t;
        @(posedge clk);
        while (node_stall)
            @(posedge clk);
        expand_node(t);
        @(negedge clk);
        node_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (basis_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_order(input logic [DEG_W-1:0] ord);
        wait_drained();
        repeat (4) @(negedge clk);
        order_we    = 1'b1;
        order_wdata = ord;
        @(negedge clk);
        order_we  = 1'b0;
        order_cfg = ord;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_node();
        if ($urandom_range(0, 4) == 0)
            return VAL_W'($urandom);
        return VAL_W'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic test_reset_order();
        send_node(VAL_W'(0));
        send_node(VAL_W'(UNIT));
        send_node(-VAL_W'(UNIT));
    endtask

    // +-1 at order 63 drives U and the slope to their limits
    task automatic test_node_extremes();
        set_order(ORDER_MAX);
        send_node(VAL_W'(65536));
        send_node(VAL_W'(-65536));
        send_node(VAL_W'(131071));
        send_node(VAL_W'(-131072));
        send_node(VAL_W'(65537));
        send_node(VAL_W'(-65537));
        send_node(VAL_W'(1));
        send_node(VAL_W'(-1));
        send_node(VAL_W'(32768));
    endtask

    task automatic test_order_extremes();
        set_order(DEG_W'(0));
        send_node(VAL_W'(12345));
        send_node(VAL_W'(-40000));
        set_order(DEG_W'(1));
        send_node(VAL_W'(-23456));
        send_node(VAL_W'(65536));
        set_order(DEG_W'(2));
        send_node(VAL_W'(50000));
    endtask

    task automatic test_drain_pause();
        set_order(DEG_W'(5));
        for (int k = 0; k < 6; k++)
        begin
            send_node(rand_node());
            wait_drained();
        end
    endtask

    task automatic test_random(input int phases, input int per_phase);
        logic [DEG_W-1:0] ord;
        for (int p = 0; p < phases; p++)
        begin
            if ($urandom_range(0, 7) == 0)
                ord = ORDER_MAX;
            else
                ord = DEG_W'($urandom_range(0, 12));
            set_order(ord);
            for (int k = 0; k < per_phase; k++)
                send_node(rand_node());
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        order_we      = 1'b0;
        order_wdata   = '0;
        node_valid    = 1'b0;
        node          = '0;
        res_stall     = 1'b0;
        fail_count    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 27;
        recv_idle_pct = 71;
        order_cfg     = ORDER_RESET;
        held_t        = 0;
        t_hist[0]     = 0;
        t_hist[1]     = 0;
        u_hist[0]     = 0;
        u_hist[1]     = 0;
        deg_count     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_order();
        test_node_extremes();
        test_order_extremes();
        test_random(4, 27);

        send_idle_pct = 71;
        recv_idle_pct = 27;
        test_drain_pause();
        test_random(4, 27);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(4, 27);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && basis_q.size() == 0)
            $display("** chebyshev_basis_with_derivative_core: PASSED **");
        else
            $display("** chebyshev_basis_with_derivative_core: FAILED **");
        $finish;
    end

endmodule
